[rtl/assert_macros.svh]
// Assertion macros used by the port-level checker of the path normalizer.
// No dependencies; include this file by its bare name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define APN_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define APN_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/apn_pkg.sv]
// Shared types and constants of the absolute path normalizer.
// No dependencies; used by the controller, the datapath and the top level.
package apn_pkg;

  localparam logic [7:0] SLASH = 8'h2F;
  localparam logic [7:0] DOT   = 8'h2E;

  typedef enum logic [1:0] {
    ST_OK,
    ST_NOT_ABS,
    ST_TOO_LONG,
    ST_ABOVE_ROOT
  } apn_status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_TAKE,
    S_PUTC,
    S_WALK_RD,
    S_WALK_CHK,
    S_CLOSE,
    S_CHOOSE,
    S_SINGLE,
    S_EMIT_RD,
    S_EMIT_OUT
  } apn_state_t;

  typedef struct packed {
    logic latch;
    logic take;
    logic putc;
    logic close;
    logic walk_chk;
    logic single_ld;
    logic emit_ld;
    logic rd_emit;
  } apn_cmd_t;

  typedef struct packed {
    logic take_putc;
    logic take_walk;
    logic close_walk;
    logic walk_done;
    logic single_path;
    logic out_free;
    logic emit_last;
    logic last_item;
  } apn_stat_t;

endpackage

[rtl/apn_ctrl.sv]
// Controller state machine of the absolute path normalizer.
// Depends on apn_pkg; drives the datapath through command and status structs.
module apn_ctrl
  import apn_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  apn_stat_t stat,
  output apn_cmd_t  cmd
);

  apn_state_t state_r;
  apn_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_TAKE;
      end
      S_TAKE: begin
        if (stat.take_putc) state_nxt = S_PUTC;
        else if (stat.take_walk) state_nxt = S_WALK_RD;
        else if (stat.last_item) state_nxt = S_CLOSE;
        else state_nxt = S_IDLE;
      end
      S_PUTC: begin
        state_nxt = stat.last_item ? S_CLOSE : S_IDLE;
      end
      S_WALK_RD: begin
        state_nxt = S_WALK_CHK;
      end
      S_WALK_CHK: begin
        if (stat.walk_done) state_nxt = stat.last_item ? S_CLOSE : S_IDLE;
        else state_nxt = S_WALK_RD;
      end
      S_CLOSE: begin
        state_nxt = stat.close_walk ? S_WALK_RD : S_CHOOSE;
      end
      S_CHOOSE: begin
        state_nxt = stat.single_path ? S_SINGLE : S_EMIT_RD;
      end
      S_SINGLE: begin
        if (stat.out_free) state_nxt = S_IDLE;
      end
      S_EMIT_RD: begin
        state_nxt = S_EMIT_OUT;
      end
      S_EMIT_OUT: begin
        if (stat.out_free) state_nxt = stat.emit_last ? S_IDLE : S_EMIT_RD;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready  = 1'b1;
        cmd.latch = in_valid;
      end
      S_TAKE: begin
        cmd.take = 1'b1;
      end
      S_PUTC: begin
        cmd.putc = 1'b1;
      end
      S_WALK_CHK: begin
        cmd.walk_chk = 1'b1;
      end
      S_CLOSE: begin
        cmd.close = 1'b1;
      end
      S_SINGLE: begin
        cmd.single_ld = stat.out_free;
      end
      S_EMIT_RD: begin
        cmd.rd_emit = 1'b1;
      end
      S_EMIT_OUT: begin
        cmd.rd_emit = 1'b1;
        cmd.emit_ld = stat.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

[rtl/apn_dpath.sv]
// Datapath of the absolute path normalizer: path store, counters and output register.
// Depends on apn_pkg; sequenced by apn_ctrl through command and status structs.
module apn_dpath
  import apn_pkg::*;
#(
  parameter int MAX_PATH = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  apn_cmd_t    cmd,
  output apn_stat_t   stat,
  input  logic [7:0]  in_char,
  input  logic        in_last,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_char,
  output apn_status_t out_status,
  output logic        out_last
);

  localparam int CW = $clog2(MAX_PATH + 1);
  localparam int AW = $clog2(MAX_PATH);
  localparam logic [CW-1:0] LIMIT = CW'(MAX_PATH - 1);
  localparam logic [CW-1:0] ONE   = CW'(1);

  logic [7:0] store_mem [MAX_PATH];
  logic [7:0] rd_data_r;

  logic [CW-1:0] kept_r, kept_nxt;
  logic [CW-1:0] start_r, start_nxt;
  logic [CW-1:0] chars_r, chars_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  apn_status_t   err_r, err_nxt;
  logic [7:0]    char_r, char_nxt;
  logic          last_r, last_nxt;
  logic          cdots_r, cdots_nxt;
  logic          oval_r, oval_nxt;
  logic [7:0]    odata_r, odata_nxt;
  apn_status_t   ostat_r, ostat_nxt;
  logic          olast_r, olast_nxt;

  logic          we;
  logic [7:0]    wdata;
  logic [AW-1:0] rd_addr;
  logic [CW-1:0] span;
  logic [CW-1:0] kept_m1;
  logic          open_comp;
  logic          is_dot;
  logic          is_dotdot;
  logic          dd_walk;
  logic          c_slash;
  logic          c_dot;
  logic          take_ok;
  logic          close_now;
  logic          clear;

  assign span      = kept_r - start_r;
  assign kept_m1   = kept_r - ONE;
  assign open_comp = kept_r > start_r;
  assign is_dot    = open_comp && (span == CW'(2)) && cdots_r;
  assign is_dotdot = open_comp && (span == CW'(3)) && cdots_r;
  assign dd_walk   = is_dotdot && (start_r != '0);
  assign c_slash   = (char_r == SLASH);
  assign c_dot     = (char_r == DOT);
  assign take_ok   = (err_r == ST_OK) && !((chars_r == '0) && !c_slash) && (chars_r < LIMIT);
  assign rd_addr   = cmd.rd_emit ? idx_r[AW-1:0] : kept_m1[AW-1:0];

  assign stat.take_putc   = take_ok && !c_slash && !open_comp;
  assign stat.take_walk   = take_ok && c_slash && dd_walk;
  assign stat.close_walk  = (err_r == ST_OK) && dd_walk;
  assign stat.walk_done   = (rd_data_r == SLASH) || (kept_r == ONE);
  assign stat.single_path = (err_r != ST_OK) || (kept_r == '0);
  assign stat.out_free    = !oval_r || out_ready;
  assign stat.emit_last   = ((idx_r + ONE) == kept_r);
  assign stat.last_item   = last_r;

  always_ff @(posedge clk) begin
    if (we) store_mem[kept_r[AW-1:0]] <= wdata;
    rd_data_r <= store_mem[rd_addr];
  end

  always_comb begin
    kept_nxt  = kept_r;
    start_nxt = start_r;
    chars_nxt = chars_r;
    idx_nxt   = idx_r;
    err_nxt   = err_r;
    char_nxt  = char_r;
    last_nxt  = last_r;
    cdots_nxt = cdots_r;
    odata_nxt = odata_r;
    ostat_nxt = ostat_r;
    olast_nxt = olast_r;
    oval_nxt  = out_ready ? 1'b0 : oval_r;
    we        = 1'b0;
    wdata     = char_r;
    close_now = 1'b0;
    clear     = 1'b0;

    if (cmd.latch) begin
      char_nxt = in_char;
      last_nxt = in_last;
    end

    if (cmd.take && (err_r == ST_OK)) begin
      if ((chars_r == '0) && !c_slash) begin
        err_nxt = ST_NOT_ABS;
      end else if (chars_r >= LIMIT) begin
        err_nxt = ST_TOO_LONG;
      end else begin
        chars_nxt = chars_r + ONE;
        if (c_slash) begin
          close_now = 1'b1;
        end else if (!open_comp) begin
          we       = 1'b1;
          wdata    = SLASH;
          kept_nxt = kept_r + ONE;
        end else begin
          we        = 1'b1;
          kept_nxt  = kept_r + ONE;
          cdots_nxt = cdots_r & c_dot;
        end
      end
    end

    if (cmd.close && (err_r == ST_OK)) close_now = 1'b1;

    if (close_now && open_comp) begin
      if (is_dot) begin
        kept_nxt = start_r;
      end else if (is_dotdot) begin
        kept_nxt = start_r;
        if (start_r == '0) err_nxt = ST_ABOVE_ROOT;
      end else begin
        start_nxt = kept_r;
      end
    end

    if (cmd.putc) begin
      we        = 1'b1;
      kept_nxt  = kept_r + ONE;
      cdots_nxt = c_dot;
    end

    if (cmd.walk_chk) begin
      kept_nxt  = kept_m1;
      start_nxt = kept_m1;
    end

    if (cmd.single_ld) begin
      oval_nxt  = 1'b1;
      odata_nxt = (err_r != ST_OK) ? 8'h00 : SLASH;
      ostat_nxt = err_r;
      olast_nxt = 1'b1;
      clear     = 1'b1;
    end

    if (cmd.emit_ld) begin
      oval_nxt  = 1'b1;
      odata_nxt = rd_data_r;
      ostat_nxt = ST_OK;
      olast_nxt = stat.emit_last;
      idx_nxt   = idx_r + ONE;
      clear     = stat.emit_last;
    end

    if (clear) begin
      kept_nxt  = '0;
      start_nxt = '0;
      chars_nxt = '0;
      idx_nxt   = '0;
      err_nxt   = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kept_r  <= '0;
      start_r <= '0;
      chars_r <= '0;
      idx_r   <= '0;
      err_r   <= ST_OK;
      last_r  <= 1'b0;
      oval_r  <= 1'b0;
    end else begin
      kept_r  <= kept_nxt;
      start_r <= start_nxt;
      chars_r <= chars_nxt;
      idx_r   <= idx_nxt;
      err_r   <= err_nxt;
      last_r  <= last_nxt;
      oval_r  <= oval_nxt;
    end
  end

  always_ff @(posedge clk) begin
    char_r  <= char_nxt;
    cdots_r <= cdots_nxt;
    odata_r <= odata_nxt;
    ostat_r <= ostat_nxt;
    olast_r <= olast_nxt;
  end

  assign out_valid  = oval_r;
  assign out_char   = odata_r;
  assign out_status = ostat_r;
  assign out_last   = olast_r;

endmodule

[rtl/absolute_path_normalizer.sv]
// Top level of the absolute path normalizer: controller plus datapath.
// Depends on apn_pkg, apn_ctrl and apn_dpath.
//
// The block takes an absolute path one byte per input transaction, with
// in_tlast on the last byte, and returns its canonical form one byte per
// output transaction, with out_tlast on the last one. Runs of slashes
// collapse, "." components vanish and ".." removes the previous component;
// an empty result is sent as "/". A path that does not start with '/', is
// longer than MAX_PATH-1 bytes or climbs above the root produces a single
// transaction with data 0 and the error code in out_tuser. Each byte passes
// the take state, one that opens a component also the put state; a ".."
// walks the store back through a read and a check state per removed byte,
// as the store has one registered read port. After the last byte the block
// closes the last component and picks the output form, plus the walk and
// a second close if the path ends in "..", and the result leaves through a
// read and an output state per byte. Only one path is in work at a time,
// but the output register lets the next path start while the previous
// final transaction still waits. The store needs no clearing after reset.
module absolute_path_normalizer
  import apn_pkg::*;
#(
  parameter int MAX_PATH = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] character
  input  logic       in_tlast,
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] out_char
  output logic [1:0] out_tuser,  // [1:0] status
  output logic       out_tlast
);

  apn_cmd_t    cmd;
  apn_stat_t   stat;
  apn_status_t out_status;

  apn_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  apn_dpath #(
    .MAX_PATH (MAX_PATH)
  ) u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .in_char    (in_tdata),
    .in_last    (in_tlast),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_char   (out_tdata),
    .out_status (out_status),
    .out_last   (out_tlast)
  );

  assign out_tuser = out_status;

endmodule

[rtl/apn_checker.sv]
// Port-level checks of the absolute path normalizer, bound to the top level.
// Depends on assert_macros.svh and the ports of absolute_path_normalizer.
`include "assert_macros.svh"

module apn_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_tvalid,
  input logic       in_tready,
  input logic [7:0] in_tdata,
  input logic       in_tlast,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic [1:0] out_tuser,
  input logic       out_tlast
);

  `APN_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready,
    out_tvalid && $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast),
    "stalled output transaction changed")
  `APN_ASSERT_NOW(a_err_shape, clk, rst_n, out_tvalid && (out_tuser != 2'd0),
    (out_tdata == 8'h00) && out_tlast, "error transaction must carry zero data and be last")
  `APN_ASSERT_NEXT(a_busy_after_take, clk, rst_n, in_tvalid && in_tready, !in_tready,
    "input accepted while the previous byte is still in work")
  `APN_ASSERT_NOW(a_emit_busy, clk, rst_n, out_tvalid && !out_tlast,
    !in_tready && (out_tuser == 2'd0), "input ready or error status in the middle of a path")

endmodule

bind absolute_path_normalizer apn_checker u_apn_checker (.*);

[tb/testbench.sv]
`timescale 1ns / 100ps
// Self-checking testbench of absolute_path_normalizer: a scoreboard class predicts the
// canonical path or error transaction for every path sent. Depends on apn_pkg and the RTL.
module testbench;
  import apn_pkg::*;

  localparam int MAX_PATH     = 64;
  localparam int HOLD_CYCLES  = 400;
  localparam int QUIET_LIMIT  = 4000;
  localparam int DRAIN_CYCLES = 200;
  localparam int ITEM_TARGET  = 110;

  typedef struct packed {
    logic [7:0]  ch;
    apn_status_t st;
    logic        last;
  } path_byte_t;

  class path_scoreboard;
    logic [7:0]  store [64];
    logic [6:0]  kept_len;
    logic [6:0]  comp_start;
    logic [6:0]  seen;
    apn_status_t err;
    path_byte_t  expected [$];
    int          failures;

    function new();
      failures = 0;
      clear_path();
    endfunction

    function void clear_path();
      foreach (store[i]) store[i] = 8'h00;
      kept_len   = '0;
      comp_start = '0;
      seen       = '0;
      err        = ST_OK;
    endfunction

    function void close_component();
      int   len;
      logic is_dot;
      logic is_dotdot;
      if (kept_len <= comp_start) begin
        comp_start = kept_len;
        return;
      end
      len = int'(kept_len) - int'(comp_start) - 1;
      is_dot = (len == 1) && (store[(comp_start + 1) % 64] == DOT);
      is_dotdot = (len == 2) && (store[(comp_start + 1) % 64] == DOT) &&
                  (store[(comp_start + 2) % 64] == DOT);
      if (is_dot) begin
        kept_len = comp_start;
      end else if (is_dotdot) begin
        kept_len = comp_start;
        if (kept_len == 0) begin
          err = ST_ABOVE_ROOT;
        end else begin
          while (kept_len > 0 && store[(kept_len - 1) % 64] != SLASH) kept_len--;
          if (kept_len > 0) kept_len--;
        end
      end
      comp_start = kept_len;
    endfunction

    function void take_char(logic [7:0] c);
      if (seen == 0 && c != SLASH) begin
        err = ST_NOT_ABS;
        return;
      end
      if (int'(seen) + 1 > MAX_PATH - 1) begin
        err = ST_TOO_LONG;
        return;
      end
      seen++;
      if (c == SLASH) begin
        close_component();
        return;
      end
      if (kept_len <= comp_start) begin
        comp_start = kept_len;
        store[kept_len % 64] = SLASH;
        kept_len++;
      end
      store[kept_len % 64] = c;
      kept_len++;
    endfunction

    function void note_input(logic [7:0] c, logic fin);
      if (err == ST_OK) take_char(c);
      if (!fin) return;
      if (err == ST_OK) close_component();
      if (err != ST_OK) begin
        expected.push_back('{ch: 8'h00, st: err, last: 1'b1});
      end else if (kept_len == 0) begin
        expected.push_back('{ch: SLASH, st: ST_OK, last: 1'b1});
      end else begin
        for (int i = 0; i < kept_len; i++)
          expected.push_back('{ch: store[i], st: ST_OK, last: (i + 1 == kept_len)});
      end
      clear_path();
    endfunction

    function void check_result(logic [7:0] ch, logic [1:0] st, logic last);
      path_byte_t want;
      if (expected.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("unexpected output transaction: char %h status %0d last %b", ch, st, last);
        return;
      end
      want = expected.pop_front();
      if (ch !== want.ch || st !== want.st || last !== want.last) begin
        failures++;
        if (failures <= 10)
          $display("mismatch: expected char %h status %0d last %b, got char %h status %0d last %b",
                   want.ch, want.st, want.last, ch, st, last);
      end
    endfunction

    function int pending();
      return expected.size();
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_tvalid = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata = 8'h00;
  logic       in_tlast = 1'b0;
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;
  logic [1:0] out_tuser;
  logic       out_tlast;

  path_scoreboard board;
  bit tx_idle_on = 1'b0;
  bit hold_go = 1'b0;
  int sent_items = 0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  absolute_path_normalizer #(.MAX_PATH(MAX_PATH)) DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast)
  );

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [7:0] name_byte();
    logic [7:0] b;
    if ($urandom_range(0, 99) < 70) return 8'h61 + 8'($urandom_range(0, 25));
    b = 8'($urandom_range(0, 254));
    if (b >= SLASH) b++;
    return b;
  endfunction

  function automatic void make_long_path(ref logic [7:0] q[$], input int n);
    q = {};
    q.push_back(SLASH);
    for (int i = 1; i < n; i++) q.push_back(($urandom_range(0, 7) == 0) ? SLASH : name_byte());
  endfunction

  function automatic void make_path(ref logic [7:0] q[$]);
    int kind;
    int ncomp;
    int r;
    q = {};
    kind = $urandom_range(0, 9);
    if (kind == 0) begin
      repeat ($urandom_range(1, 12)) q.push_back(8'($urandom_range(0, 255)));
      return;
    end
    ncomp = $urandom_range(0, 5);
    if (ncomp == 0) q.push_back(SLASH);
    for (int c = 0; c < ncomp; c++) begin
      repeat (($urandom_range(0, 3) == 0) ? $urandom_range(2, 3) : 1) q.push_back(SLASH);
      r = $urandom_range(0, 9);
      if (r < 2) begin
        q.push_back(DOT);
      end else if (r < 4) begin
        q.push_back(DOT);
        q.push_back(DOT);
      end else begin
        repeat ($urandom_range(1, 4)) q.push_back(name_byte());
      end
    end
    if ($urandom_range(0, 1) == 1) q.push_back(SLASH);
    if (kind == 1) q[0] = name_byte();
  endfunction

  task automatic send_item(input logic [7:0] c, input logic fin);
    int gap;
    gap = tx_idle_on ? pick_gap() : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= c;
    in_tlast  <= fin;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    board.note_input(c, fin);
    sent_items++;
  endtask

  task automatic send_path(input logic [7:0] q[$]);
    tx_idle_on = ($urandom_range(0, 3) != 0);
    foreach (q[i]) send_item(q[i], i == q.size() - 1);
  endtask

  task automatic send_text(input string s);
    logic [7:0] q[$];
    for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
    send_path(q);
  endtask

  // Receiver: random stalls in changing modes, plus one long hold-off on request.
  int rx_stall = 0;
  int rx_hold = 0;
  int rx_cycle = 0;
  bit rx_idle_on = 1'b1;
  bit held_done = 1'b0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) board.check_result(out_tdata, out_tuser, out_tlast);
      rx_cycle++;
      if (rx_cycle % 64 == 0) rx_idle_on = ($urandom_range(0, 2) != 0);
      if (hold_go && !held_done) begin
        held_done = 1'b1;
        rx_hold = HOLD_CYCLES;
      end
      if (rx_hold > 0) begin
        rx_hold--;
        out_tready <= 1'b0;
      end else if (rx_stall > 0) begin
        rx_stall--;
        out_tready <= 1'b0;
      end else begin
        rx_stall = rx_idle_on ? pick_gap() : 0;
        out_tready <= (rx_stall == 0);
        if (rx_stall > 0) rx_stall--;
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet = 0;
      else quiet++;
    end
    $display("testbench: FAIL");
    $finish;
  end

  initial begin : stimulus
    logic [7:0] q[$];
    int paths;
    board = new();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_text("/");
    send_text("q/");
    send_text("/../b");
    send_text("//a/./b/..");
    q = {SLASH, 8'h00, SLASH, 8'hFF};
    send_path(q);
    send_text("/...");

    paths = 0;
    while (sent_items < ITEM_TARGET) begin
      if (paths == 1) begin
        hold_go <= 1'b1;
        make_long_path(q, MAX_PATH);
      end else begin
        make_path(q);
      end
      send_path(q);
      paths++;
    end
    in_tvalid <= 1'b0;

    while (board.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (board.failures == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
